/* rtl/command_line_editor_matcher_assert.svh */
// Assertion macros for the command line editor and matcher.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef COMMAND_LINE_EDITOR_MATCHER_ASSERT_SVH
`define COMMAND_LINE_EDITOR_MATCHER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CLEM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cle_pkg.sv */
// Shared types, character codes and command name table for the line editor.
// No dependencies; imported by every module of the block except cle_ram.
package cle_pkg;

    localparam int LINE_LEN_DEF     = 64;
    localparam int NUM_COMMANDS_DEF = 32;
    localparam int NAME_LEN_DEF     = 12;

    // front queue
    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_BS   = 2'd1,
        KIND_EOL  = 2'd2
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  ch;
    } fq_entry_t;

    typedef struct packed {
        logic       valid;
        fq_entry_t  entry;
    } fq_head_t;

    typedef enum logic [1:0] {
        STAT_MATCHED   = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_TOO_LONG  = 2'd2,
        STAT_NO_NAME   = 2'd3
    } result_status_t;

    typedef struct packed {
        result_status_t  status;
        logic [4:0]      command_index;
        logic [6:0]      param_start;
        logic [6:0]      line_length;
    } result_t;

    // built-in command names, zero padded
    localparam int NUM_BUILTIN = 4;
    localparam int BUILTIN_MAX = 9;

    localparam logic [7:0] BUILTIN_NAMES [NUM_BUILTIN][BUILTIN_MAX] = '{
        '{8'h56, 8'h49, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // VIN
        '{8'h54, 8'h49, 8'h4D, 8'h45, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00},  // TIMER
        '{8'h50, 8'h52, 8'h49, 8'h4E, 8'h54, 8'h43, 8'h4D, 8'h44, 8'h00},  // PRINTCMD
        '{8'h48, 8'h45, 8'h4C, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}   // HELP
    };

    localparam logic [5:0] BUILTIN_LEN [NUM_BUILTIN] = '{6'd3, 6'd5, 6'd8, 6'd4};

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    // byte of the name ROM; bytes past the name length read as zero
    function automatic logic [7:0] rom_byte(input logic [7:0] idx, input logic [4:0] pos);
        logic [7:0] b;
        b = 8'h00;
        if (idx < 8'(NUM_BUILTIN) && pos < 5'(BUILTIN_MAX))
        begin
            b = BUILTIN_NAMES[idx[1:0]][pos[3:0]];
        end
        return b;
    endfunction

    // name length of a ROM entry, capped at name_len
    function automatic logic [5:0] rom_name_len(input logic [7:0] idx,
                                                input logic [5:0] name_len);
        logic [5:0] n;
        n = 6'd0;
        if (idx < 8'(NUM_BUILTIN))
        begin
            n = BUILTIN_LEN[idx[1:0]];
            if (n > name_len)
            begin
                n = name_len;
            end
        end
        return n;
    endfunction

endpackage

/* rtl/cle_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]          wr_data,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/cle_front.sv */
// Front end: takes received words, classifies them and queues them.
// Depends on cle_pkg.
module cle_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         char_code,
    input  logic               take,
    output cle_pkg::fq_head_t  head
);
    import cle_pkg::*;

    fq_entry_t          slot_reg [FQ_DEPTH];
    logic [FQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FQ_AW:0]     cnt_reg, cnt_next;
    logic               do_push, do_take;
    fq_entry_t          new_entry;

    assign full    = (cnt_reg == (FQ_AW+1)'(FQ_DEPTH));
    assign do_push = push && !full;
    assign do_take = take && (cnt_reg != '0);

    always_comb
    begin
        new_entry.ch = char_code;
        unique case (char_code)
            CH_LF, CH_CR: new_entry.kind = KIND_EOL;
            CH_BS:        new_entry.kind = KIND_BS;
            default:      new_entry.kind = KIND_CHAR;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_take)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_take)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_take && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

endmodule

/* rtl/cle_back.sv */
// Back end: line editing, command name scan and ROM match, result register.
// Depends on cle_pkg and cle_ram.
module cle_back #(
    parameter int LINE_LEN     = cle_pkg::LINE_LEN_DEF,
    parameter int NUM_COMMANDS = cle_pkg::NUM_COMMANDS_DEF,
    parameter int NAME_LEN     = cle_pkg::NAME_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cle_pkg::fq_head_t  head,
    output logic               take,
    input  logic               pop,
    output logic               res_valid,
    output cle_pkg::result_t   res_word
);
    import cle_pkg::*;

    localparam int CW  = $clog2(LINE_LEN + 2);
    localparam int AW  = $clog2(LINE_LEN);
    localparam int MW  = (CW > 6) ? CW : 6;
    localparam int NIW = $clog2(NAME_LEN);
    localparam int CIW = (NUM_COMMANDS > 1) ? $clog2(NUM_COMMANDS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_BSCHK  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_MATCH  = 5'b01000,
        ST_RESULT = 5'b10000
    } back_state_t;

    back_state_t      state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             quote_reg, quote_next;
    logic [CW-1:0]    scan_pos_reg, scan_pos_next;
    logic [CW-1:0]    len_reg, len_next;
    logic [CIW-1:0]   cmd_reg, cmd_next;
    logic [7:0]       name_reg [NAME_LEN];
    result_t          res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic             ram_wr_en, ram_rd_en;
    logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
    logic [7:0]       ram_wr_data, ram_rd_data;
    logic             name_wr;
    logic [CW-1:0]    pos_inc;
    logic             scan_done;
    logic [CW-1:0]    scan_len;
    logic             quote_toggled;
    logic             name_hit;
    logic [5:0]       rom_len;

    cle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_LEN)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign take = (state_reg == ST_IDLE) && head.valid;

    // one ROM entry compared per cycle, all name bytes at once
    always_comb
    begin
        rom_len  = rom_name_len(8'(cmd_reg), 6'(NAME_LEN));
        name_hit = (MW'(rom_len) == MW'(len_reg));
        for (int k = 0; k < NAME_LEN; k++)
        begin
            if ((MW'(k) < MW'(len_reg)) && (name_reg[k] != rom_byte(8'(cmd_reg), 5'(k))))
            begin
                name_hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        quote_next     = quote_reg;
        scan_pos_next  = scan_pos_reg;
        len_next       = len_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = AW'(count_reg);
        ram_wr_data    = head.entry.ch;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;
        name_wr        = 1'b0;
        pos_inc        = scan_pos_reg + CW'(1);
        scan_done      = 1'b0;
        scan_len       = scan_pos_reg;
        quote_toggled  = quote_reg ^ (head.entry.ch == CH_QUOTE);

        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    unique case (head.entry.kind)
                        KIND_CHAR:
                        begin
                            quote_next = quote_toggled;
                            if (!quote_toggled && head.entry.ch >= 8'h61
                                && head.entry.ch <= 8'h7A)
                            begin
                                ram_wr_data = head.entry.ch - 8'd32;
                            end
                            if (count_reg < CW'(LINE_LEN))
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else if (count_reg == CW'(LINE_LEN))
                            begin
                                count_next = count_reg + CW'(1);  // overshoot mark
                            end
                        end
                        KIND_BS:
                        begin
                            if (count_reg > CW'(LINE_LEN))
                            begin
                                count_next = CW'(LINE_LEN);
                            end
                            else if (count_reg != '0)
                            begin
                                count_next  = count_reg - CW'(1);
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = AW'(count_reg - CW'(1));
                                state_next  = ST_BSCHK;
                            end
                        end
                        KIND_EOL:
                        begin
                            quote_next = 1'b0;
                            if (count_reg > CW'(LINE_LEN))
                            begin
                                res_next.status        = STAT_TOO_LONG;
                                res_next.command_index = '0;
                                res_next.param_start   = '0;
                                res_next.line_length   = 7'(LINE_LEN);
                                state_next             = ST_RESULT;
                            end
                            else if (count_reg != '0)
                            begin
                                res_next.line_length = 7'(count_reg);
                                ram_rd_en            = 1'b1;
                                ram_rd_addr          = '0;
                                scan_pos_next        = '0;
                                state_next           = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_BSCHK:
            begin
                // removed a quote: undo its toggle
                if (ram_rd_data == CH_QUOTE)
                begin
                    quote_next = ~quote_reg;
                end
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                if (is_name_char(ram_rd_data))
                begin
                    name_wr = (MW'(scan_pos_reg) < MW'(NAME_LEN));
                    if (pos_inc == count_reg)
                    begin
                        scan_done = 1'b1;
                        scan_len  = pos_inc;
                    end
                    else
                    begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = AW'(pos_inc);
                        scan_pos_next = pos_inc;
                    end
                end
                else
                begin
                    scan_done = 1'b1;
                end

                if (scan_done)
                begin
                    len_next = scan_len;
                    if (scan_len == '0)
                    begin
                        res_next.status        = STAT_NO_NAME;
                        res_next.command_index = '0;
                        res_next.param_start   = '0;
                        state_next             = ST_RESULT;
                    end
                    else
                    begin
                        cmd_next   = '0;
                        state_next = ST_MATCH;
                    end
                end
            end

            ST_MATCH:
            begin
                res_next.param_start = 7'(len_reg + CW'(1));
                if (name_hit)
                begin
                    res_next.status        = STAT_MATCHED;
                    res_next.command_index = 5'(cmd_reg);
                    state_next             = ST_RESULT;
                end
                else if (cmd_reg == CIW'(NUM_COMMANDS - 1))
                begin
                    res_next.status        = STAT_NOT_FOUND;
                    res_next.command_index = '0;
                    state_next             = ST_RESULT;
                end
                else
                begin
                    cmd_next = cmd_reg + CIW'(1);
                end
            end

            ST_RESULT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            quote_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            quote_reg     <= quote_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_pos_reg <= scan_pos_next;
        len_reg      <= len_next;
        cmd_reg      <= cmd_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
        if (name_wr)
        begin
            name_reg[NIW'(scan_pos_reg)] <= ram_rd_data;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

endmodule

/* rtl/command_line_editor_matcher.sv */
// Top level of the command line editor and command name matcher.
// Depends on cle_pkg, cle_front, cle_back (with cle_ram) and the assertion header.
//
// Received words go in through a queue-style port (push/full) and land in a
// four-entry front queue, so the sender only sees full when four words are
// already waiting. The back end edits the line one word at a time: an
// ordinary character or a backspace on an overshot or empty line is handled
// in the idle state alone, a backspace that removes a stored character also
// passes through a check state (the line RAM read is registered, and the
// removed byte decides whether the quote mode flips back). A CR or LF on a
// non-empty line starts the lookup: the name scan reads the line RAM one
// byte a cycle, then the ROM is walked one command per cycle (all name bytes
// of an entry are compared at once) until the first hit or the last entry,
// and the result state hands the result to the output register. An overlong
// line reports straight away. The result waits in the output register
// (empty/pop) while the next line is already being edited; the back end
// only stalls if a second result is ready before the first is popped.
// Results: status 0 matched, 1 not found, 2 line too long, 3 no command
// name; command_index is zero unless matched; param_start is the name
// length plus one for status 0 and 1.

`include "command_line_editor_matcher_assert.svh"

module command_line_editor_matcher #(
    parameter int LINE_LEN     = cle_pkg::LINE_LEN_DEF,
    parameter int NUM_COMMANDS = cle_pkg::NUM_COMMANDS_DEF,
    parameter int NAME_LEN     = cle_pkg::NAME_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_code,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [4:0]  command_index,
    output logic [6:0]  param_start,
    output logic [6:0]  line_length
);
    import cle_pkg::*;

    fq_head_t  fq_head;
    logic      fq_take;
    logic      res_valid;
    result_t   res_word;

    // front: classify and queue received words
    cle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .char_code (char_code),
        .take      (fq_take),
        .head      (fq_head)
    );

    // back: edit the line, scan and match, hold the result word
    cle_back #(
        .LINE_LEN     (LINE_LEN),
        .NUM_COMMANDS (NUM_COMMANDS),
        .NAME_LEN     (NAME_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (fq_head),
        .take      (fq_take),
        .pop       (pop),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    assign empty         = !res_valid;
    assign status        = res_word.status;
    assign command_index = res_word.command_index;
    assign param_start   = res_word.param_start;
    assign line_length   = res_word.line_length;

    // only a match carries an index
    `CLEM_ASSERT_IMPLY(a_index_only_on_match,
        !empty && status != STAT_MATCHED, command_index == 5'd0,
        "command index set on a result that is not a match")

    // a matched name is never empty, so parameters start past position zero
    `CLEM_ASSERT_IMPLY(a_match_has_name,
        !empty && status == STAT_MATCHED, param_start != 7'd0,
        "match reported with empty command name")

    // overlong line reports the full length and no parameters
    `CLEM_ASSERT_IMPLY(a_too_long_fields,
        !empty && status == STAT_TOO_LONG,
        line_length == 7'(LINE_LEN) && param_start == 7'd0,
        "overlong line result fields wrong")

    // a waiting word stays put until it is popped
    `CLEM_ASSERT_NEXT(a_hold_until_pop,
        !empty && !pop,
        !empty && $stable({status, command_index, param_start, line_length}),
        "result word changed or vanished before it was popped")

endmodule

/* dv/tb_command_line_editor_matcher.sv */
// Self-checking bench for command_line_editor_matcher: drives received words, predicts the
// line reports with a model of the line editor and name lookup, and checks every report.
// Depends on cle_pkg and the RTL of the block only.
module tb_command_line_editor_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import cle_pkg::*;

    localparam int LINE_LEN     = 64;
    localparam int NUM_COMMANDS = 32;
    localparam int NAME_LEN     = 12;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int TOTAL_WORDS  = 450;
    // room for the longest line end after the last word, plus margin
    localparam int DRAIN_CYCLES = LINE_LEN + NUM_COMMANDS + 40;
    // ~500 words at worst-case gaps plus ~100 line ends with worst-case pop stalls
    // stay well under this limit
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // only the first four ROM entries hold names; the zero entries never match
    localparam int NUM_NAMED = 4;

    typedef struct packed {
        result_status_t status;
        logic [4:0]     command_index;
        logic [6:0]     param_start;
        logic [6:0]     line_length;
    } line_report_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] char_code;
    logic       empty;
    logic       pop;
    logic [1:0] status;
    logic [4:0] command_index;
    logic [6:0] param_start;
    logic [6:0] line_length;

    command_line_editor_matcher #(
        .LINE_LEN     (LINE_LEN),
        .NUM_COMMANDS (NUM_COMMANDS),
        .NAME_LEN     (NAME_LEN)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_code     (char_code),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .command_index (command_index),
        .param_start   (param_start),
        .line_length   (line_length)
    );

    // command names as held in the ROM (all shorter than NAME_LEN, so none truncated)
    string cmd_names [NUM_NAMED] = '{"VIN", "TIMER", "PRINTCMD", "HELP"};

    // ------------------------------------------------------------------
    // Line model: our own copy of the edited line, its fill level and the
    // quote mode. Fill runs 0..LINE_LEN+1; LINE_LEN+1 marks an overshoot.
    // ------------------------------------------------------------------
    logic [7:0]   line_buf [LINE_LEN];
    int unsigned  line_fill;
    bit           in_quotes;

    line_report_t line_reports_q [$];   // reports predicted but not yet popped
    logic [7:0]   chars_to_send_q [$];  // words waiting for the driver

    int unsigned  errors;
    int unsigned  words_queued;
    int unsigned  words_sent;
    int unsigned  reports_checked;
    int unsigned  status_seen [4];
    int unsigned  cycle_count;

    int unsigned  send_gap;
    int unsigned  pop_stall;
    bit           send_calm;
    bit           recv_calm;
    line_report_t want;

    function automatic bit is_cmd_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
    endfunction

    function automatic bit name_equals(input int idx, input int unsigned len);
        string s;
        s = cmd_names[idx];
        if (s.len() != len)
            return 1'b0;
        for (int k = 0; k < len; k++)
        begin
            if (line_buf[k] != s[k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one accepted word to the line model; a line end on a
    // non-empty line queues the report the block has to produce.
    function automatic void edit_line(input logic [7:0] c);
        line_report_t r;
        int unsigned  name_len;
        bit           hit;
        if (c != CH_LF && c != CH_CR)
        begin
            // a quote toggles even when the line is full and it is dropped
            if (c == CH_QUOTE)
                in_quotes = !in_quotes;
            if (c == CH_BS)
            begin
                // removing a quote undoes its toggle; on overshoot nothing is removed
                if (line_fill != 0)
                begin
                    line_fill--;
                    if (line_fill < LINE_LEN && line_buf[line_fill] == CH_QUOTE)
                        in_quotes = !in_quotes;
                end
            end
            else if (line_fill < LINE_LEN)
            begin
                line_buf[line_fill] = (!in_quotes && c >= "a" && c <= "z") ?
                                      c - CASE_OFFSET : c;
                line_fill++;
            end
            else
            begin
                line_fill = LINE_LEN + 1;
            end
            return;
        end

        in_quotes = 1'b0;
        if (line_fill == 0)
            return;

        r.status        = STAT_NO_NAME;
        r.command_index = '0;
        r.param_start   = '0;
        r.line_length   = 7'(line_fill);
        if (line_fill > LINE_LEN)
        begin
            r.status      = STAT_TOO_LONG;
            r.line_length = 7'(LINE_LEN);
        end
        else
        begin
            name_len = 0;
            while (name_len < line_fill && is_cmd_char(line_buf[name_len]))
                name_len++;
            if (name_len != 0)
            begin
                r.status      = STAT_NOT_FOUND;
                r.param_start = 7'(name_len + 1);
                hit = 1'b0;
                // lowest matching entry wins
                for (int i = 0; i < NUM_NAMED && !hit; i++)
                begin
                    if (name_equals(i, name_len))
                    begin
                        hit             = 1'b1;
                        r.status        = STAT_MATCHED;
                        r.command_index = 5'(i);
                    end
                end
            end
        end
        line_fill = 0;
        status_seen[r.status]++;
        line_reports_q.push_back(r);
    endfunction

    // Mostly short gaps, some longer ones, the odd very long one; a calm
    // stretch gives back-to-back traffic.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(input string what, input int unsigned exp_val,
                                        input logic [6:0] got);
        if (got !== 7'(exp_val))
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_val, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d reports still due",
                     $time, cycle_count, line_reports_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: accepts at the rising edge, presents the next word at the
    // falling edge. push only moves at the falling edge, so it is never
    // lowered and raised within one step.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            edit_line(char_code);
            void'(chars_to_send_q.pop_front());
            words_sent++;
            if ($urandom_range(0, 39) == 0)
                send_calm = !send_calm;
            send_gap = pick_gap(send_calm);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (send_gap != 0)
        begin
            push <= 1'b0;
            send_gap--;
        end
        else if (chars_to_send_q.size() != 0)
        begin
            push      <= 1'b1;
            char_code <= chars_to_send_q[0];
        end
        else
        begin
            push <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each popped report is checked against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (line_reports_q.size() == 0)
            begin
                errors++;
                $display("%0t: report with none expected: status %0d index %0d start %0d len %0d",
                         $time, status, command_index, param_start, line_length);
            end
            else
            begin
                want = line_reports_q.pop_front();
                check_field("status", want.status, status);
                check_field("command_index", want.command_index, command_index);
                check_field("param_start", want.param_start, param_start);
                check_field("line_length", want.line_length, line_length);
                reports_checked++;
            end
            if ($urandom_range(0, 29) == 0)
                recv_calm = !recv_calm;
            pop_stall = pick_gap(recv_calm);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (pop_stall != 0)
        begin
            pop <= 1'b0;
            pop_stall--;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [7:0] w);
        chars_to_send_q.push_back(w);
        words_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int k = 0; k < s.len(); k++)
            queue_word(s[k]);
    endtask

    function automatic logic [7:0] random_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1)
            return c + CASE_OFFSET;
        return c;
    endfunction

    function automatic logic [7:0] rand_name_char();
        int unsigned r;
        r = $urandom_range(0, 35);
        return random_case((r < 26) ? 8'("A" + r) : 8'("0" + r - 26));
    endfunction

    function automatic logic [7:0] rand_printable();
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic logic [7:0] rand_line_end();
        return ($urandom_range(0, 1) == 1) ? CH_CR : CH_LF;
    endfunction

    // A known name, a space, then printable filler up to n characters; with
    // trim set, a few backspaces before the line end (the first one lands on
    // the overshoot mark when n is past LINE_LEN).
    task automatic queue_long_line(input int n, input bit trim);
        string name;
        int    len;
        name = cmd_names[$urandom_range(0, NUM_NAMED - 1)];
        queue_text(name);
        queue_word(CH_SPACE);
        len = name.len() + 1;
        while (len < n)
        begin
            queue_word(rand_printable());
            len++;
        end
        if (trim)
        begin
            repeat ($urandom_range(1, 4))
                queue_word(CH_BS);
        end
        queue_word(rand_line_end());
    endtask

    // Nearly half the lines open with a name, in random case with optional parameters;
    // the rest edit with backspaces and quotes, start with a non-name
    // character, run long, or are raw noise.
    task automatic queue_random_line();
        int    kind;
        string name;
        kind = $urandom_range(0, 99);
        if (kind < 6)
        begin
            queue_long_line(int'($urandom_range(60, 72)), 1'($urandom_range(0, 1)));
        end
        else
        begin
            if (kind < 50)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    repeat ($urandom_range(1, 10))
                        queue_word(rand_name_char());
                end
                else
                begin
                    name = cmd_names[$urandom_range(0, NUM_NAMED - 1)];
                    // sometimes only a prefix, sometimes one character too many
                    if ($urandom_range(0, 5) == 0)
                        name = name.substr(0, name.len() - 2);
                    for (int k = 0; k < name.len(); k++)
                        queue_word(random_case(name[k]));
                    if ($urandom_range(0, 5) == 0)
                        queue_word(rand_name_char());
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    queue_word(CH_SPACE);
                    repeat ($urandom_range(0, 8))
                        queue_word(rand_printable());
                end
            end
            else if (kind < 65)
            begin
                repeat ($urandom_range(1, 10))
                begin
                    case ($urandom_range(0, 3))
                        0:       queue_word(CH_BS);
                        1:       queue_word(CH_QUOTE);
                        default: queue_word(rand_name_char());
                    endcase
                end
            end
            else if (kind < 80)
            begin
                queue_word(($urandom_range(0, 1) == 1) ? CH_QUOTE : CH_SPACE);
                repeat ($urandom_range(0, 6))
                    queue_word(rand_printable());
            end
            else
            begin
                // may carry its own line ends and backspaces
                repeat ($urandom_range(1, 6))
                    queue_word(8'($urandom_range(0, 255)));
            end
            queue_word(rand_line_end());
        end
    endtask

    // Sender holds off until every word is in and every report is out.
    task automatic wait_idle();
        while (chars_to_send_q.size() != 0 || line_reports_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        char_code = 8'h00;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words
        queue_word(CH_CR);                  // line end on an empty line: no report
        queue_word(CH_BS);                  // backspace on an empty line: ignored
        queue_text("VIN");                  // exact match, entry 0
        queue_word(CH_CR);
        queue_text("p\"");                  // quote removed again by backspace,
        queue_word(CH_BS);                  // so x is still folded to upper case
        queue_text("x");
        queue_word(CH_LF);
        queue_word(8'h00);                  // byte extremes, no command name
        queue_word(8'hFF);
        queue_word(CH_CR);
        queue_text("\"a");                  // leading quote: no name; quote mode
        queue_word(CH_CR);                  // cleared at the line end
        queue_text("help \"q\"");           // match with quoted lower-case parameter
        queue_word(CH_LF);
        wait_idle();

        // full line, then an overshoot trimmed back with backspaces
        queue_long_line(LINE_LEN, 1'b0);
        queue_long_line(LINE_LEN + 3, 1'b1);
        while (words_queued < TOTAL_WORDS / 2)
            queue_random_line();
        wait_idle();
        while (words_queued < TOTAL_WORDS)
            queue_random_line();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        errors += line_reports_q.size();

        $display("Sent %0d words, checked %0d line reports", words_sent, reports_checked);
        $display("Reports by status: matched %0d, not found %0d, too long %0d, no name %0d",
                 status_seen[STAT_MATCHED], status_seen[STAT_NOT_FOUND],
                 status_seen[STAT_TOO_LONG], status_seen[STAT_NO_NAME]);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/cle_pkg.sv
rtl/cle_ram.sv
rtl/cle_front.sv
rtl/cle_back.sv
rtl/command_line_editor_matcher.sv
dv/tb_command_line_editor_matcher.sv
